// ===== design/point_in_triangle_tolerant_assert.svh =====
// Assertion macros for the point-in-triangle block.
`ifndef POINT_IN_TRIANGLE_TOLERANT_ASSERT_SVH
`define POINT_IN_TRIANGLE_TOLERANT_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define PIT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent a fixed number of cycles later.
`define PIT_ASSERT_LATER(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== design/pit_pkg.sv =====
`default_nettype none
package pit_pkg;
  localparam int CoordWidth = 16;
  localparam int TolWidth   = 24;
  localparam int Latency    = 6;

  typedef enum logic [1:0] {
    DEC_BOX    = 2'd0,
    DEC_SIGNS  = 2'd1,
    DEC_NEAR   = 2'd2,
    DEC_OUTSIDE = 2'd3
  } decided_t;
endpackage
`default_nettype wire

// ===== design/point_in_triangle_tolerant.sv =====
// Channel   | Direction | Handshake          | Payload
// input     | in        | start, busy        | v0_x..v2_y, pt_x, pt_y
// result    | out       | done (one cycle)   | inside_res, decided_by
// config    | in        | tol_we             | tol_wdata
// One item may enter every cycle; busy is held low (never back-pressured).
// Each result is registered through six register
// stages: differences, products, sums, square halves, compare, decision.
// Synchronous active-high reset clears the valid bits and the tolerance.
// The receiver cannot stall, so nothing inside ever holds.
`default_nettype none
module point_in_triangle_tolerant
  import pit_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic signed [COORD_WIDTH-1:0] v0_x,
  input  wire logic signed [COORD_WIDTH-1:0] v0_y,
  input  wire logic signed [COORD_WIDTH-1:0] v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] pt_x,
  input  wire logic signed [COORD_WIDTH-1:0] pt_y,
  input  wire logic                          tol_we,
  input  wire logic [TolWidth-1:0]           tol_wdata,
  output      logic                          done,
  output      logic                          inside_res,
  output      logic [1:0]                    decided_by
);
  localparam int DW = COORD_WIDTH + 1;    // difference
  localparam int PW = 2 * DW;             // product
  localparam int SW = PW + 1;             // sum of two products
  localparam int QW = 2 * SW;             // square of a sum
  localparam int RW = SW + TolWidth;      // length times tolerance

  logic [TolWidth-1:0] tol;
  always_ff @(posedge clk) begin
    if (rst) tol <= '0;
    else if (tol_we) tol <= tol_wdata;
  end

  assign busy = 1'b0;

  // ---- stage 1: differences and bounding box
  logic [Latency-1:0] vld;
  logic signed [DW-1:0] s1_ex [3];
  logic signed [DW-1:0] s1_ey [3];
  logic signed [DW-1:0] s1_dx [3];
  logic signed [DW-1:0] s1_dy [3];
  logic signed [DW-1:0] s1_fx [3];   // point minus segment end
  logic signed [DW-1:0] s1_fy [3];
  logic                 s1_rej;

  logic signed [DW-1:0] ax [3];
  logic signed [DW-1:0] ay [3];
  logic signed [DW-1:0] px, py;
  always_comb begin
    ax[0] = DW'(v0_x); ay[0] = DW'(v0_y);
    ax[1] = DW'(v1_x); ay[1] = DW'(v1_y);
    ax[2] = DW'(v2_x); ay[2] = DW'(v2_y);
    px = DW'(pt_x); py = DW'(pt_y);
  end

  logic box_rej;
  always_comb begin
    box_rej = 1'b0;
    if (px > ax[0] && px > ax[1] && px > ax[2]) box_rej = 1'b1;
    if (px < ax[0] && px < ax[1] && px < ax[2]) box_rej = 1'b1;
    if (py > ay[0] && py > ay[1] && py > ay[2]) box_rej = 1'b1;
    if (py < ay[0] && py < ay[1] && py < ay[2]) box_rej = 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_ex[i] <= ax[(i + 1) % 3] - ax[i];
      s1_ey[i] <= ay[(i + 1) % 3] - ay[i];
      s1_dx[i] <= px - ax[i];
      s1_dy[i] <= py - ay[i];
      s1_fx[i] <= px - ax[(i + 1) % 3];
      s1_fy[i] <= py - ay[(i + 1) % 3];
    end
    s1_rej <= box_rej;
  end

  // ---- stage 2: products
  logic signed [PW-1:0] s2_c1 [3], s2_c2 [3];
  logic signed [PW-1:0] s2_d1 [3], s2_d2 [3];
  logic signed [PW-1:0] s2_l1 [3], s2_l2 [3];
  logic signed [PW-1:0] s2_a1 [3], s2_a2 [3];
  logic signed [PW-1:0] s2_b1 [3], s2_b2 [3];
  logic                 s2_rej;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_c1[i] <= s1_ex[i] * s1_dy[i];
      s2_c2[i] <= s1_ey[i] * s1_dx[i];
      s2_d1[i] <= s1_dx[i] * s1_ex[i];
      s2_d2[i] <= s1_dy[i] * s1_ey[i];
      s2_l1[i] <= s1_ex[i] * s1_ex[i];
      s2_l2[i] <= s1_ey[i] * s1_ey[i];
      s2_a1[i] <= s1_dx[i] * s1_dx[i];
      s2_a2[i] <= s1_dy[i] * s1_dy[i];
      s2_b1[i] <= s1_fx[i] * s1_fx[i];
      s2_b2[i] <= s1_fy[i] * s1_fy[i];
    end
    s2_rej <= s1_rej;
  end

  // ---- stage 3: sums, signs, end cases
  logic signed [SW-1:0] s3_cr [3];
  logic [SW-1:0]        s3_len [3];
  logic [2:0]           s3_pos, s3_nearend, s3_mid;
  logic                 s3_rej;
  logic [TolWidth-1:0]  s3_tol;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SW-1:0] cr, dt, ln, da, db;
      cr = SW'(s2_c1[i]) - SW'(s2_c2[i]);
      dt = SW'(s2_d1[i]) + SW'(s2_d2[i]);
      ln = SW'(s2_l1[i]) + SW'(s2_l2[i]);
      da = SW'(s2_a1[i]) + SW'(s2_a2[i]);
      db = SW'(s2_b1[i]) + SW'(s2_b2[i]);
      s3_cr[i]  <= (cr < 0) ? -cr : cr;
      s3_len[i] <= ln;
      s3_pos[i] <= (cr > 0);
      if (dt <= 0) begin
        s3_nearend[i] <= (da < $signed({1'b0, tol}));
        s3_mid[i]     <= 1'b0;
      end else if (dt >= ln) begin
        s3_nearend[i] <= (db < $signed({1'b0, tol}));
        s3_mid[i]     <= 1'b0;
      end else begin
        s3_nearend[i] <= 1'b0;
        s3_mid[i]     <= 1'b1;
      end
    end
    s3_rej <= s2_rej;
    s3_tol <= tol;
  end

  // ---- stage 4: split squares into halves (cross^2 and len*tol)
  localparam int HW = (SW + 1) / 2;
  logic [2*HW-1:0] s4_hh [3], s4_hl [3], s4_ll [3];
  logic [RW-1:0]   s4_rhs [3];
  logic [2:0]      s4_pos, s4_nearend, s4_mid;
  logic            s4_rej;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [2*HW-1:0] c;
      c = (2*HW)'(s3_cr[i]);
      s4_hh[i]  <= c[2*HW-1:HW] * c[2*HW-1:HW];
      s4_hl[i]  <= c[2*HW-1:HW] * c[HW-1:0];
      s4_ll[i]  <= c[HW-1:0] * c[HW-1:0];
      s4_rhs[i] <= RW'(s3_len[i]) * RW'(s3_tol);
    end
    s4_pos <= s3_pos; s4_nearend <= s3_nearend; s4_mid <= s3_mid;
    s4_rej <= s3_rej;
  end

  // ---- stage 5: assemble square, compare
  logic [2:0] s5_pos, s5_near;
  logic       s5_rej;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [4*HW:0] sq;
      sq = ((4*HW+1)'(s4_hh[i]) << (2*HW)) + ((4*HW+1)'(s4_hl[i]) << (HW + 1))
           + (4*HW+1)'(s4_ll[i]);
      s5_near[i] <= s4_nearend[i] ||
                    (s4_mid[i] && (sq < (4*HW+1)'(s4_rhs[i])));
    end
    s5_pos <= s4_pos;
    s5_rej <= s4_rej;
  end

  // ---- stage 6: decision
  always_ff @(posedge clk) begin
    if (s5_rej) begin
      inside_res <= 1'b0; decided_by <= DEC_BOX;
    end else if (s5_pos == 3'b000 || s5_pos == 3'b111) begin
      inside_res <= 1'b1; decided_by <= DEC_SIGNS;
    end else if (s5_near != 3'b000) begin
      inside_res <= 1'b1; decided_by <= DEC_NEAR;
    end else begin
      inside_res <= 1'b0; decided_by <= DEC_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Latency-2:0], start};
  end
  assign done = vld[Latency-1];
endmodule
`default_nettype wire

// ===== design/pit_checker.sv =====
`default_nettype none
`include "point_in_triangle_tolerant_assert.svh"
module pit_checker
  import pit_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       inside_res,
  input wire logic [1:0] decided_by
);
  `PIT_ASSERT_LATER(a_done_follows, clk, rst, start && !busy, 6, done, "result missing")
  `PIT_ASSERT_NOW(a_box_out, clk, rst, done && decided_by == DEC_BOX, !inside_res, "box reject inside")
  `PIT_ASSERT_NOW(a_near_in, clk, rst, done && (decided_by == DEC_NEAR || decided_by == DEC_SIGNS), inside_res, "inside flag wrong")
  `PIT_ASSERT_NOW(a_out_flag, clk, rst, done && decided_by == DEC_OUTSIDE, !inside_res, "outside flag wrong")
endmodule

bind point_in_triangle_tolerant pit_checker u_pit_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .inside_res(inside_res), .decided_by(decided_by)
);
`default_nettype wire

// ===== tb/point_in_triangle_tolerant_test.sv =====
module point_in_triangle_tolerant_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pit_pkg::*;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic     flag;
    decided_t dec;
  } verdict_t;

  class verdict_board;
    verdict_t pending[$];
    logic [TolWidth-1:0] tol;
    int errors;
    int checked;
    int hits[4];

    function logic side_right(longint ax, longint ay, longint bx, longint by,
                              longint px, longint py);
      longint c;
      c = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
      return c > 0;
    endfunction

    // exact squared-distance test against a segment, no division
    function logic near_seg(longint ax, longint ay, longint bx, longint by,
                            longint px, longint py);
      longint ex, ey, dx, dy, dot, len2, c, qx, qy;
      logic [127:0] lhs, rhs;
      ex = bx - ax; ey = by - ay; dx = px - ax; dy = py - ay;
      dot = dx * ex + dy * ey;
      if (dot <= 0) return (dx * dx + dy * dy) < longint'(tol);
      len2 = ex * ex + ey * ey;
      if (dot >= len2) begin
        qx = px - bx; qy = py - by;
        return (qx * qx + qy * qy) < longint'(tol);
      end
      c = ex * dy - ey * dx;
      if (c < 0) c = -c;
      lhs = 128'(c) * 128'(c);
      rhs = 128'(len2) * 128'(tol);
      return lhs < rhs;
    endfunction

    function void note_item(coord_t q[8]);
      longint x0, y0, x1, y1, x2, y2, px, py;
      logic sa, sb, sc;
      verdict_t r;
      x0 = q[0]; y0 = q[1]; x1 = q[2]; y1 = q[3];
      x2 = q[4]; y2 = q[5]; px = q[6]; py = q[7];
      if (px > ((x0 > x1 ? x0 : x1) > x2 ? (x0 > x1 ? x0 : x1) : x2) ||
          px < ((x0 < x1 ? x0 : x1) < x2 ? (x0 < x1 ? x0 : x1) : x2) ||
          py > ((y0 > y1 ? y0 : y1) > y2 ? (y0 > y1 ? y0 : y1) : y2) ||
          py < ((y0 < y1 ? y0 : y1) < y2 ? (y0 < y1 ? y0 : y1) : y2)) begin
        r = '{1'b0, DEC_BOX};
      end else begin
        sa = side_right(x0, y0, x1, y1, px, py);
        sb = side_right(x1, y1, x2, y2, px, py);
        sc = side_right(x2, y2, x0, y0, px, py);
        if (sa == sb && sa == sc) r = '{1'b1, DEC_SIGNS};
        else if (near_seg(x0, y0, x1, y1, px, py) || near_seg(x1, y1, x2, y2, px, py) ||
                 near_seg(x2, y2, x0, y0, px, py)) r = '{1'b1, DEC_NEAR};
        else r = '{1'b0, DEC_OUTSIDE};
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic flag, logic [1:0] dec);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result inside=%0b decided_by=%0d", $time, flag, dec);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      hits[e.dec]++;
      if (flag !== e.flag) begin
        $display("%0t: inside_res expected %0b actual %0b", $time, e.flag, flag);
        errors++;
      end
      if (dec !== e.dec) begin
        $display("%0t: decided_by expected %0d actual %0d", $time, e.dec, dec);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t v0_x = '0, v0_y = '0, v1_x = '0, v1_y = '0;
  coord_t v2_x = '0, v2_y = '0, pt_x = '0, pt_y = '0;
  logic tol_we = 1'b0;
  logic [TolWidth-1:0] tol_wdata = '0;
  logic done, inside_res;
  logic [1:0] decided_by;

  verdict_board board = new();

  always #5 clk = ~clk;

  point_in_triangle_tolerant dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y),
    .v2_x(v2_x), .v2_y(v2_y), .pt_x(pt_x), .pt_y(pt_y),
    .tol_we(tol_we), .tol_wdata(tol_wdata),
    .done(done), .inside_res(inside_res), .decided_by(decided_by)
  );

  always @(posedge clk) begin
    if (!rst && done) board.check_result(inside_res, decided_by);
  end

  // hold start high across back-to-back beats; drop on a gap or after a phase's last beat
  task automatic send_beat(coord_t q[8], bit keep);
    start <= 1'b1;
    {v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, pt_x, pt_y} <=
      {q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]};
    do @(posedge clk); while (busy);
    board.note_item(q);
    if (!keep) start <= 1'b0;
  endtask

  task automatic write_tolerance(logic [TolWidth-1:0] val);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
    tol_we <= 1'b1;
    tol_wdata <= val;
    @(posedge clk);
    tol_we <= 1'b0;
    board.tol = val;
  endtask

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  // mostly triangles with points near them so every decision path shows up
  function automatic void make_item(output coord_t q[8]);
    int span;
    int mode;
    int j;
    mode = $urandom_range(9);
    span = mode < 2 ? 0 : ($urandom_range(1) ? 64 : 4096);
    for (j = 0; j < 6; j++) q[j] = rnd_coord(span);
    if (mode == 9) begin
      j = $urandom_range(2);
      q[6] = coord_t'((longint'(q[2*j]) + longint'(q[2*((j+1)%3)])) / 2
                      + longint'($urandom_range(4)) - 2);
      q[7] = coord_t'((longint'(q[2*j+1]) + longint'(q[2*((j+1)%3)+1])) / 2
                      + longint'($urandom_range(4)) - 2);
    end else if (mode == 8) begin
      q[4] = q[2];
      q[5] = q[3];
      q[6] = rnd_coord(span);
      q[7] = rnd_coord(span);
    end else begin
      q[6] = rnd_coord(span);
      q[7] = rnd_coord(span);
    end
  endfunction

  task automatic random_phase(int count);
    coord_t q[8];
    int burst;
    int gap;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      gap = $urandom_range(1) ? $urandom_range(1, 6) : 0;
      while (burst > 0 && k < count) begin
        make_item(q);
        burst--;
        k++;
        send_beat(q, k < count && (burst > 0 || gap == 0));
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    coord_t q[8];
    coord_t mx, mn;
    mx = coord_t'(16'sh7FFF);
    mn = coord_t'(16'sh8000);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_tolerance(24'd0);
    // extremes of the coordinate range
    q = '{mn, mn, mx, mn, mn, mx, mn, mn}; send_beat(q, 1);
    q = '{mn, mn, mx, mn, mn, mx, mx, mx}; send_beat(q, 1);
    q = '{mn, mn, mx, mn, mn, mx, 16'sd0, 16'sd0}; send_beat(q, 1);
    q = '{mx, mx, mn, mx, mx, mn, 16'sd0, 16'sd0}; send_beat(q, 1);
    q = '{mx, mx, mx, mx, mx, mx, mx, mx}; send_beat(q, 1);
    // box border, point on an edge line, degenerate edge
    q = '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0};
    send_beat(q, 1);
    q = '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 16'sd2048, 16'sd0};
    send_beat(q, 1);
    q = '{16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0, 16'sd4096, 16'sd3000, 16'sd10};
    send_beat(q, 1);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd10, 16'sd12};
    send_beat(q, 1);
    random_phase(60);

    write_tolerance(24'hFFFFFF);
    q = '{16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0, 16'sd4096, 16'sd3000, 16'sd10};
    send_beat(q, 1);
    q = '{mn, mn, mx, mx, mn, mx, mx, mn}; send_beat(q, 1);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd10, 16'sd12};
    send_beat(q, 1);
    random_phase(130);

    write_tolerance(24'd40000);
    random_phase(110);
    write_tolerance(24'd1);
    random_phase(50);
    write_tolerance(24'(($urandom_range(1) << 23) | $urandom_range(24'h7FFFFF)));
    random_phase(50);

    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    $display("Checked %0d results: %0d box rejects, %0d sign agreements, %0d near-edge, %0d outside",
             board.checked, board.hits[0], board.hits[1], board.hits[2], board.hits[3]);
    $display("Tolerance settings covered: zero, full scale, mid, one and a random value");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== point_in_triangle_tolerant.f =====
+incdir+design
design/pit_pkg.sv
design/point_in_triangle_tolerant.sv
design/pit_checker.sv
tb/point_in_triangle_tolerant_test.sv
